// ===== hdl/cc20_pkg.sv =====
// shared types, constants and helpers for the chacha20 keystream generator
// no dependencies; used by cc20_datapath, cc20_ctrl and the top level
package cc20_pkg;

  localparam int ROUND_PAIRS_DEFAULT = 10;
  localparam int BLOCK_BYTES = 64;
  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_1 = 3'd5;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;        // working state <= initial state
    logic       round_step;  // one add/xor/rotate step of four quarter rounds
    logic [1:0] step_idx;    // which of the four steps of a quarter round
    logic       diag;        // diagonal half round, else column
    logic       add_back;    // add initial state, bump block counter
    logic       out_load;    // load output register from the buffer
    logic       out_last;    // last flag for that byte
    logic [5:0] rd_off;      // byte offset into the keystream block
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== hdl/cc20_datapath.sv =====
// datapath: key/nonce registers, block counter, 16-word working state that
// also serves as the keystream buffer, and the output register; uses cc20_pkg
module cc20_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_hit,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cc20_pkg::cmd_t                      cmd,
  output logic [7:0]                          data_byte,
  output logic                                last
);

  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] block_counter;
  logic [31:0] work [16];
  logic [31:0] work_next [16];
  logic [31:0] init_w [16];
  logic [31:0] rd_word;

  // initial block state
  always_comb begin
    init_w[0] = cc20_pkg::SIGMA_0;
    init_w[1] = cc20_pkg::SIGMA_1;
    init_w[2] = cc20_pkg::SIGMA_2;
    init_w[3] = cc20_pkg::SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_reg[i][31:0];
      init_w[5 + 2 * i] = key_reg[i][63:32];
    end
    init_w[12] = block_counter;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
  end

  // one step of four quarter rounds in parallel, or load, or add-back
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a, b, c, d, s;
    ia = '0;
    ib = '0;
    ic = '0;
    id = '0;
    a  = '0;
    b  = '0;
    c  = '0;
    d  = '0;
    s  = '0;
    work_next = work;
    if (cmd.load) begin
      work_next = init_w;
    end else if (cmd.round_step) begin
      for (int q = 0; q < 4; q++) begin
        ia = 4'(q);
        if (cmd.diag) begin
          ib = 4'(4 + ((q + 1) & 3));
          ic = 4'(8 + ((q + 2) & 3));
          id = 4'(12 + ((q + 3) & 3));
        end else begin
          ib = 4'(4 + q);
          ic = 4'(8 + q);
          id = 4'(12 + q);
        end
        a = work[ia];
        b = work[ib];
        c = work[ic];
        d = work[id];
        if (!cmd.step_idx[0]) begin
          s = a + b;
          work_next[ia] = s;
          work_next[id] = cmd.step_idx[1] ? cc20_pkg::rotl(d ^ s, 8)
                                          : cc20_pkg::rotl(d ^ s, 16);
        end else begin
          s = c + d;
          work_next[ic] = s;
          work_next[ib] = cmd.step_idx[1] ? cc20_pkg::rotl(b ^ s, 7)
                                          : cc20_pkg::rotl(b ^ s, 12);
        end
      end
    end else if (cmd.add_back) begin
      for (int i = 0; i < 16; i++) begin
        work_next[i] = work[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
  end

  // configuration and block counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_reg[i] <= '0;
      end
      nonce_lo      <= '0;
      nonce_hi      <= '0;
      block_counter <= '0;
    end else if (cfg_hit) begin
      block_counter <= '0;
      case (cfg_index)
        cc20_pkg::REG_KEY_0:   key_reg[0] <= cfg_data;
        cc20_pkg::REG_KEY_1:   key_reg[1] <= cfg_data;
        cc20_pkg::REG_KEY_2:   key_reg[2] <= cfg_data;
        cc20_pkg::REG_KEY_3:   key_reg[3] <= cfg_data;
        cc20_pkg::REG_NONCE_0: nonce_lo <= cfg_data;
        cc20_pkg::REG_NONCE_1: nonce_hi <= cfg_data[31:0];
        default: ;
      endcase
    end else if (cmd.add_back) begin
      block_counter <= block_counter + 32'd1;
    end
  end

  // byte read from the buffer into the output register
  assign rd_word = work[cmd.rd_off[5:2]];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      data_byte <= rd_word[{cmd.rd_off[1:0], 3'b000} +: 8];
      last      <= cmd.out_last;
    end
  end

endmodule

// ===== hdl/cc20_ctrl.sv =====
// controller: request intake, byte sequencing, round scheduling and output
// valid; drives cc20_datapath through cc20_pkg::cmd_t
module cc20_ctrl #(
  parameter int ROUND_PAIRS = cc20_pkg::ROUND_PAIRS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_hit,
  input  logic           req_valid,
  output logic           req_stall,
  input  logic [6:0]     byte_count,
  output logic           ks_valid,
  input  logic           ks_stall,
  output cc20_pkg::cmd_t cmd
);

  localparam int HR_W = $clog2(2 * ROUND_PAIRS);
  localparam logic [HR_W-1:0] HR_LAST = HR_W'(2 * ROUND_PAIRS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;
  localparam logic [1:0] S_ADD   = 2'd3;

  logic [1:0]      state, state_next;
  logic [6:0]      offset, offset_next;
  logic [6:0]      remaining, remaining_next;
  logic [1:0]      step, step_next;
  logic [HR_W-1:0] half_round, half_round_next;
  logic            ks_valid_next;
  logic            out_free;
  logic [6:0]      req_bytes;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !ks_valid || !ks_stall;
  assign req_bytes = byte_count[6] ? 7'(cc20_pkg::BLOCK_BYTES) : byte_count;

  always_comb begin
    state_next      = state;
    offset_next     = offset;
    remaining_next  = remaining;
    step_next       = step;
    half_round_next = half_round;
    ks_valid_next   = ks_valid && ks_stall;
    cmd             = '0;
    cmd.rd_off      = offset[5:0];
    cmd.step_idx    = step;
    cmd.diag        = half_round[0];
    case (state)
      S_IDLE: begin
        if (req_valid && req_bytes != 7'd0) begin
          remaining_next = req_bytes;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (offset[6]) begin
          cmd.load        = 1'b1;
          step_next       = '0;
          half_round_next = '0;
          state_next      = S_ROUND;
        end else if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = (remaining == 7'd1);
          ks_valid_next  = 1'b1;
          offset_next    = offset + 7'd1;
          remaining_next = remaining - 7'd1;
          if (remaining == 7'd1) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        step_next      = step + 2'd1;
        if (step == 2'd3) begin
          half_round_next = half_round + HR_W'(1);
          if (half_round == HR_LAST) begin
            state_next = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.add_back = 1'b1;
        offset_next  = '0;
        state_next   = S_EMIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_hit) begin
      offset_next = 7'(cc20_pkg::BLOCK_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      offset     <= 7'(cc20_pkg::BLOCK_BYTES);
      remaining  <= '0;
      step       <= '0;
      half_round <= '0;
      ks_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      offset     <= offset_next;
      remaining  <= remaining_next;
      step       <= step_next;
      half_round <= half_round_next;
      ks_valid   <= ks_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset <= 7'(cc20_pkg::BLOCK_BYTES))
    else $error("buffer offset beyond block");

  a_busy_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (remaining != 7'd0))
    else $error("busy with nothing left to send");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == S_IDLE))
    else $error("last byte sent without returning to idle");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !offset[6])
    else $error("byte read from an empty buffer");

  a_rounds_then_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && step == 2'd3 && half_round == HR_LAST) |=> (state == S_ADD))
    else $error("round sequence did not end in add-back");
`endif

endmodule

// ===== hdl/chacha20_keystream_byte_generator.sv =====
// top level of the chacha20 keystream byte generator
// instantiates cc20_ctrl and cc20_datapath; constants from cc20_pkg
//
//  channel  | valid      | flow control | payload
//  ---------+------------+--------------+------------------------------
//  request  | req_valid  | req_stall    | byte_count (1..64, >64 -> 64)
//  keystream| ks_valid   | ks_stall     | data_byte, last
//  config   | cfg_valid  | cfg_ready    | cfg_index, cfg_data
//
// a request for n bytes (count clamped to 64) is served one byte per cycle out
// of the 16-word block buffer while the sink does not stall and the buffer
// holds bytes; when the buffer runs dry a new block is built from one load,
// four add/xor/rotate steps per half round on four quarter rounds at once,
// and one add-back of the initial state
// a request is taken only while idle; output stalls hold the byte sequencer
// synchronous reset clears the key, nonce and block counter and empties the
// buffer; a config write to any register does the same for counter and buffer
module chacha20_keystream_byte_generator #(
  parameter int ROUND_PAIRS = cc20_pkg::ROUND_PAIRS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [6:0]                      byte_count,
  // keystream channel
  output logic                            ks_valid,
  input  logic                            ks_stall,
  output logic [7:0]                      data_byte,
  output logic                            last,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data
);

  cc20_pkg::cmd_t cmd;
  logic           cfg_hit;

  // writes always complete; an index past the register list is dropped
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < cc20_pkg::CFG_IDX_W'(cc20_pkg::NUM_REGS));

  cc20_ctrl #(
    .ROUND_PAIRS (ROUND_PAIRS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_hit    (cfg_hit),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .byte_count (byte_count),
    .ks_valid   (ks_valid),
    .ks_stall   (ks_stall),
    .cmd        (cmd)
  );

  cc20_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_hit   (cfg_hit),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .data_byte (data_byte),
    .last      (last)
  );

endmodule

// ===== dv/cc20_keystream_check_pkg.sv =====
// keystream tracker for the chacha20 keystream byte generator bench
// predicts every byte from its own copy of key, nonce, counter and block buffer
// depends on cc20_pkg for sizes, sigma words and register indexes
package cc20_keystream_check_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } ks_byte_t;

  class chacha_keystream_tracker;
    int          double_rounds;
    logic [63:0] key_nonce[cc20_pkg::NUM_REGS];
    logic [31:0] block_ctr;
    logic [7:0]  ks_block[cc20_pkg::BLOCK_BYTES];
    int unsigned used;
    logic [31:0] mix[16];
    ks_byte_t    awaited_bytes[$];
    int unsigned requests;
    int unsigned bytes_checked;
    int unsigned writes;
    int unsigned errors;

    function new(int rounds);
      double_rounds = rounds;
      foreach (key_nonce[i]) key_nonce[i] = '0;
      foreach (ks_block[i]) ks_block[i] = '0;
      block_ctr = '0;
      used = cc20_pkg::BLOCK_BYTES;
      requests = 0;
      bytes_checked = 0;
      writes = 0;
      errors = 0;
    endfunction

    function logic [31:0] rot32(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
    endfunction

    // next 64-byte block, then bump the counter (wraps naturally at 32 bits)
    function void refill_block();
      logic [31:0] seed_w[16];
      logic [31:0] sum;
      seed_w[0] = cc20_pkg::SIGMA_0;
      seed_w[1] = cc20_pkg::SIGMA_1;
      seed_w[2] = cc20_pkg::SIGMA_2;
      seed_w[3] = cc20_pkg::SIGMA_3;
      for (int i = 0; i < 4; i++) begin
        seed_w[4 + 2 * i] = key_nonce[i][31:0];
        seed_w[5 + 2 * i] = key_nonce[i][63:32];
      end
      seed_w[12] = block_ctr;
      seed_w[13] = key_nonce[cc20_pkg::REG_NONCE_0][31:0];
      seed_w[14] = key_nonce[cc20_pkg::REG_NONCE_0][63:32];
      seed_w[15] = key_nonce[cc20_pkg::REG_NONCE_1][31:0];
      mix = seed_w;
      for (int p = 0; p < double_rounds; p++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        sum = mix[i] + seed_w[i];
        for (int k = 0; k < 4; k++) ks_block[4 * i + k] = sum[8 * k +: 8];
      end
      block_ctr += 32'd1;
      used = 0;
    endfunction

    function void write_reg(logic [cc20_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      writes++;
      if (idx >= cc20_pkg::NUM_REGS) return;
      if (idx == cc20_pkg::REG_NONCE_1) val[63:32] = '0;
      key_nonce[idx] = val;
      block_ctr = '0;
      used = cc20_pkg::BLOCK_BYTES;
    endfunction

    function void note_request(logic [6:0] count);
      int unsigned n;
      ks_byte_t b;
      requests++;
      n = (count > cc20_pkg::BLOCK_BYTES) ? cc20_pkg::BLOCK_BYTES : count;
      for (int k = 0; k < n; k++) begin
        if (used >= cc20_pkg::BLOCK_BYTES) refill_block();
        b.data_byte = ks_block[used];
        b.last = (k == n - 1);
        awaited_bytes.push_back(b);
        used++;
      end
    endfunction

    function void check_byte(logic [7:0] got_byte, logic got_last);
      ks_byte_t want;
      bytes_checked++;
      if (awaited_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected keystream byte %02h last %b", got_byte, got_last);
        return;
      end
      want = awaited_bytes.pop_front();
      if (want.data_byte !== got_byte || want.last !== got_last) begin
        errors++;
        if (errors <= 10)
          $display("byte %0d: expected %02h last %b, got %02h last %b", bytes_checked,
                   want.data_byte, want.last, got_byte, got_last);
      end
    endfunction

    function int unsigned pending();
      return awaited_bytes.size();
    endfunction

    function void close_out();
      if (awaited_bytes.size() != 0) begin
        $display("%0d keystream bytes never arrived", awaited_bytes.size());
        errors += awaited_bytes.size();
      end
    endfunction
  endclass

endpackage

// ===== dv/testbench.sv =====
// top-level bench for chacha20_keystream_byte_generator
// drives requests and key/nonce writes, checks every byte against the tracker
// depends on cc20_pkg and cc20_keystream_check_pkg
module testbench;

  localparam int DOUBLE_ROUNDS = cc20_pkg::ROUND_PAIRS_DEFAULT;
  // block build plus a full request, with margin, before touching the registers
  localparam int SETTLE_CYCLES = 8 * DOUBLE_ROUNDS + 2 * cc20_pkg::BLOCK_BYTES + 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 29;
  // indexes past the register file, writes there must be dropped
  localparam logic [cc20_pkg::CFG_IDX_W-1:0] REG_SPARE_0 =
    cc20_pkg::CFG_IDX_W'(cc20_pkg::NUM_REGS);
  localparam logic [cc20_pkg::CFG_IDX_W-1:0] REG_SPARE_1 =
    cc20_pkg::CFG_IDX_W'(cc20_pkg::NUM_REGS + 1);

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  logic [6:0]                      byte_count = '0;
  logic                            ks_valid;
  logic                            ks_stall = 1'b0;
  logic [7:0]                      data_byte;
  logic                            last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // control flags from the stimulus process, written with nonblocking assignments
  logic no_idle = 1'b0;
  logic long_hold_go = 1'b0;

  // receiver-private state, plus the watchdog cycle count and the settings tally
  logic long_hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  int   cycle_count = 0;
  int   settings = 1;

  cc20_keystream_check_pkg::chacha_keystream_tracker tracker = new(DOUBLE_ROUNDS);

  chacha20_keystream_byte_generator #(
    .ROUND_PAIRS(DOUBLE_ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .byte_count(byte_count),
    .ks_valid(ks_valid),
    .ks_stall(ks_stall),
    .data_byte(data_byte),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still awaited", cycle_count,
               tracker.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // keystream sink: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      ks_stall <= 1'b0;
    end else begin
      if (ks_valid && !ks_stall) tracker.check_byte(data_byte, last);
      // one long hold-off so the generator backs up and stalls its requests
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ks_stall <= 1'b1;
      end else if (no_idle) begin
        ks_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ks_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        ks_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 39))
          0: begin
            calm_left = $urandom_range(20, 60);
            ks_stall <= 1'b0;
          end
          1, 2, 3, 4, 5, 6, 7: begin
            // a stall burst of random length
            stall_left = $urandom_range(0, 2);
            ks_stall <= 1'b1;
          end
          default: ks_stall <= 1'b0;
        endcase
      end
    end
  end

  // offer one request and hold it until the transfer, maybe idle afterwards
  task automatic send_request(input logic [6:0] count);
    req_valid <= 1'b1;
    byte_count <= count;
    do @(posedge clk); while (req_stall);
    tracker.note_request(count);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // one register write; cfg_valid stays up for a following write
  task automatic write_cfg(input logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
  endtask

  task automatic load_key_nonce(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] n0, input logic [63:0] n1);
    write_cfg(cc20_pkg::REG_KEY_0, k0);
    write_cfg(cc20_pkg::REG_KEY_1, k1);
    write_cfg(cc20_pkg::REG_KEY_2, k2);
    write_cfg(cc20_pkg::REG_KEY_3, k3);
    write_cfg(cc20_pkg::REG_NONCE_0, n0);
    write_cfg(cc20_pkg::REG_NONCE_1, n1);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // stop offering, let every awaited byte arrive, then let the block go quiet
  task automatic drain_and_settle();
    req_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 7'(cc20_pkg::BLOCK_BYTES + $urandom_range(1, 63));
      1: return '0;
      2, 3: return 7'($urandom_range(1, 8));
      default: return 7'($urandom_range(1, cc20_pkg::BLOCK_BYTES));
    endcase
  endfunction

  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero key and nonce from reset: single byte, full block, zero and
    // oversized counts, and a request that straddles a block boundary
    send_request(7'd1);
    send_request(7'd64);
    send_request(7'd0);
    send_request(7'd65);
    send_request(7'd127);
    send_request(7'd63);
    send_request(7'd2);
    drain_and_settle();

    // writes past the register file are dropped, the stream carries on mid-block
    write_cfg(REG_SPARE_0, {$urandom, $urandom});
    write_cfg(REG_SPARE_1, '1);
    cfg_valid <= 1'b0;
    send_request(7'd5);
    send_request(7'd40);
    drain_and_settle();

    // all ones everywhere; the upper half of the last nonce register is lost
    load_key_nonce('1, '1, '1, '1, '1, '1);
    send_request(7'd64);
    send_request(7'd1);
    send_request(7'd0);
    send_request(7'd64);
    send_request(7'd3);
    drain_and_settle();

    // a lone write part-way through a block restarts counter and buffer
    write_cfg(cc20_pkg::REG_KEY_2, 64'h0123_4567_89ab_cdef);
    cfg_valid <= 1'b0;
    settings++;
    send_request(7'd10);
    send_request(7'd60);
    drain_and_settle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) no_idle <= 1'b1;
      if (ph == 1) begin
        // a few scattered writes, spare indexes included
        for (k = 0; k < $urandom_range(1, 3); k++)
          write_cfg(cc20_pkg::CFG_IDX_W'($urandom_range(0, cc20_pkg::NUM_REGS + 1)),
                    pick_reg_value());
        cfg_valid <= 1'b0;
        settings++;
      end else begin
        load_key_nonce(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                       pick_reg_value(), pick_reg_value(), {$urandom, $urandom});
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_count());
        if (ph == 0 && n == 0) long_hold_go <= 1'b1;
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          // sender goes quiet until every awaited byte is in
          req_valid <= 1'b0;
          do @(posedge clk); while (tracker.pending() != 0);
        end
      end
      drain_and_settle();
    end

    tracker.close_out();
    $display("covered %0d requests (zero, single, full-block, oversized), %0d bytes checked",
             tracker.requests, tracker.bytes_checked);
    $display("%0d register writes over %0d key/nonce settings, incl. dropped spare indexes",
             tracker.writes, settings);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cc20_pkg.sv
hdl/cc20_datapath.sv
hdl/cc20_ctrl.sv
hdl/chacha20_keystream_byte_generator.sv
dv/cc20_keystream_check_pkg.sv
dv/testbench.sv
